[sv/lsit_pkg.sv]
// ----------------------------------------------------------------------------
// lsit_pkg
// Shared constants, command codes and types of the line start index table.
// ----------------------------------------------------------------------------
package lsit_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int OFFSET_BITS_DEF = 21;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 21;
    localparam int DELTA_W = 21;
    localparam int IDX_W   = 10;
    localparam int START_W = 21;
    localparam int TOTAL_W = 11;
    localparam int ALU_W   = 32;

    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SHIFT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

    typedef struct packed {
        logic [ALU_W-1:0]          value;
        logic [POS_W-1:0]          pos;
        logic signed [DELTA_W-1:0] delta;
    } t_alu_req;

    typedef struct packed {
        logic             move;
        logic [ALU_W-1:0] sum;
    } t_alu_rsp;

endpackage

[sv/lsit_req_if.sv]
// ----------------------------------------------------------------------------
// lsit_req_if
// Request channel: command and its operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsit_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [lsit_pkg::CMD_W-1:0]            command;
    logic [lsit_pkg::BYTE_W-1:0]           text_byte;
    logic [lsit_pkg::POS_W-1:0]            edit_pos;
    logic signed [lsit_pkg::DELTA_W-1:0]   edit_delta;
    logic [lsit_pkg::IDX_W-1:0]            line_index;

    modport source (
        output valid, command, text_byte, edit_pos, edit_delta, line_index,
        input  ready
    );
    modport sink (
        input  valid, command, text_byte, edit_pos, edit_delta, line_index,
        output ready
    );
endinterface

[sv/lsit_rsp_if.sv]
// ----------------------------------------------------------------------------
// lsit_rsp_if
// Response channel: line start, totals and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsit_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lsit_pkg::START_W-1:0]    line_start;
    logic [lsit_pkg::TOTAL_W-1:0]    line_total;
    logic                            truncated;
    logic                            index_valid;

    modport source (
        output valid, line_start, line_total, truncated, index_valid,
        input  ready
    );
    modport sink (
        input  valid, line_start, line_total, truncated, index_valid,
        output ready
    );
endinterface

[sv/lsit_ram.sv]
// ----------------------------------------------------------------------------
// lsit_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lsit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/lsit_alu.sv]
// ----------------------------------------------------------------------------
// lsit_alu
// Shift unit: compares one stored start against the edit position and adds
// the sign-extended delta.
// ----------------------------------------------------------------------------
module lsit_alu (
    input  lsit_pkg::t_alu_req i_req,
    output lsit_pkg::t_alu_rsp o_rsp
);

    logic [lsit_pkg::ALU_W-1:0] pos_ext;
    logic [lsit_pkg::ALU_W-1:0] delta_ext;

    assign pos_ext   = lsit_pkg::ALU_W'(i_req.pos);
    assign delta_ext = lsit_pkg::ALU_W'(signed'(i_req.delta));

    assign o_rsp.move = (i_req.value > pos_ext);
    assign o_rsp.sum  = i_req.value + delta_ext;

endmodule

[sv/line_start_index_table_top.sv]
// ----------------------------------------------------------------------------
// line_start_index_table_top
// Line start offset table: scan text for newlines, shift starts after an
// edit, read back one line start.
// ----------------------------------------------------------------------------
//  port    dir  handshake     payload
//  i_req   in   valid/ready   command, text_byte, edit_pos, edit_delta,
//                             line_index
//  o_rsp   out  valid/ready   line_start, line_total, truncated, index_valid
//
//  Begin, scan and shift requests load their response at accept; reads
//  pass through ST_RD first (registered RAM read). A shift with nonzero
//  delta then walks the table: each entry is read in ST_SHRD and written
//  back in ST_SHWR through the shared shift unit. The table RAM needs no
//  clearing after reset. One response is held in an output register; a
//  stalled response blocks new requests while it is held.
// ----------------------------------------------------------------------------
module line_start_index_table_top #(
    parameter int MAX_ENTRIES = lsit_pkg::MAX_ENTRIES_DEF,
    parameter int OFFSET_BITS = lsit_pkg::OFFSET_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsit_req_if.sink   i_req,
    lsit_rsp_if.source o_rsp
);

    localparam int DEPTH = MAX_ENTRIES - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_SHRD = 2'd2;
    localparam logic [1:0] ST_SHWR = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [CW-1:0]                       r_count, n_count;
    logic [OFFSET_BITS-1:0]              r_pos, n_pos;
    logic                                r_ovf, n_ovf;
    logic [AW-1:0]                       r_idx, n_idx;
    logic [AW-1:0]                       r_last, n_last;
    logic                                r_rd_hit, n_rd_hit;
    logic [lsit_pkg::POS_W-1:0]          r_edit_pos, n_edit_pos;
    logic signed [lsit_pkg::DELTA_W-1:0] r_edit_delta, n_edit_delta;

    logic                                r_out_valid, n_out_valid;
    logic [lsit_pkg::START_W-1:0]        r_out_start, n_out_start;
    logic [lsit_pkg::TOTAL_W-1:0]        r_out_total, n_out_total;
    logic                                r_out_trunc, n_out_trunc;
    logic                                r_out_ivld, n_out_ivld;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [OFFSET_BITS-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [OFFSET_BITS-1:0] ram_rdata;

    lsit_pkg::t_alu_req     alu_req;
    lsit_pkg::t_alu_rsp     alu_rsp;

    logic                   accept;
    logic                   out_free;
    logic                   full;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   idx_ok;

    lsit_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign alu_req.value = lsit_pkg::ALU_W'(ram_rdata);
    assign alu_req.pos   = r_edit_pos;
    assign alu_req.delta = r_edit_delta;

    lsit_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;

    assign full    = (r_count >= CW'(MAX_ENTRIES));
    assign pos_inc = r_pos + OFFSET_BITS'(1);
    assign idx_ok  = (32'(i_req.line_index) < 32'(r_count));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_ovf        = r_ovf;
        n_idx        = r_idx;
        n_last       = r_last;
        n_rd_hit     = r_rd_hit;
        n_edit_pos   = r_edit_pos;
        n_edit_delta = r_edit_delta;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_start  = r_out_start;
        n_out_total  = r_out_total;
        n_out_trunc  = r_out_trunc;
        n_out_ivld   = r_out_ivld;

        ram_we    = 1'b0;
        ram_waddr = AW'(r_count - CW'(1));
        ram_wdata = pos_inc;
        ram_raddr = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.command)
                        lsit_pkg::CMD_BEGIN: begin
                            n_count = CW'(1);
                            n_pos   = '0;
                            n_ovf   = 1'b0;
                        end
                        lsit_pkg::CMD_SCAN: begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else if (i_req.text_byte == lsit_pkg::NEWLINE_BYTE) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                            n_pos = pos_inc;
                        end
                        lsit_pkg::CMD_SHIFT: begin
                            n_edit_pos   = i_req.edit_pos;
                            n_edit_delta = i_req.edit_delta;
                            n_idx        = '0;
                            n_last       = AW'(r_count - CW'(2));
                            if (i_req.edit_delta != '0 && r_count > CW'(1)) begin
                                n_state = ST_SHRD;
                            end
                        end
                        default: begin
                            ram_raddr = AW'(i_req.line_index - lsit_pkg::IDX_W'(1));
                            n_rd_hit  = idx_ok && (i_req.line_index != '0);
                            n_state   = ST_RD;
                        end
                    endcase
                    n_out_start = '0;
                    n_out_total = lsit_pkg::TOTAL_W'(n_count);
                    n_out_trunc = n_ovf;
                    n_out_ivld  = (i_req.command == lsit_pkg::CMD_READ) && idx_ok;
                    n_out_valid = (i_req.command != lsit_pkg::CMD_READ);
                end
            end
            ST_RD: begin
                n_out_start = r_rd_hit ? lsit_pkg::START_W'(ram_rdata) : '0;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_SHRD: begin
                n_state = ST_SHWR;
            end
            ST_SHWR: begin
                ram_we    = alu_rsp.move;
                ram_waddr = r_idx;
                ram_wdata = alu_rsp.sum[OFFSET_BITS-1:0];
                if (r_idx == r_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_SHRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= CW'(1);
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_rd_hit     <= n_rd_hit;
        r_edit_pos   <= n_edit_pos;
        r_edit_delta <= n_edit_delta;
        r_out_start  <= n_out_start;
        r_out_total  <= n_out_total;
        r_out_trunc  <= n_out_trunc;
        r_out_ivld   <= n_out_ivld;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.line_start  = r_out_start;
    assign o_rsp.line_total  = r_out_total;
    assign o_rsp.truncated   = r_out_trunc;
    assign o_rsp.index_valid = r_out_ivld;

endmodule
